// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

// File: hdl/ptmr_pkg.sv
// ----------------------------------------------------------------------------
// ptmr_pkg
// Types, constants and helpers of the resampling tap accumulator.
// ----------------------------------------------------------------------------
package ptmr_pkg;

  localparam int LANES      = 4;
  localparam int OUT_FIELDS = 4;
  localparam int SAMP_W     = 8;
  localparam int PIX_W      = 8;
  localparam int WGT_W      = 16;
  localparam int PROD_W     = WGT_W + SAMP_W + 1;
  localparam int ACC_W      = 32;
  localparam int PREC_W     = 4;
  localparam int CHAN_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [PREC_W-1:0]    PRECISION_RESET = PREC_W'(12);
  localparam logic [CHAN_W-1:0]    CHANNELS_RESET  = CHAN_W'(3);
  localparam logic [PIX_W-1:0]     PIX_MAX         = PIX_W'(255);
  localparam logic [CFG_IDX_W-1:0] REG_PRECISION   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS    = CFG_IDX_W'(1);

  typedef struct packed {
    logic [SAMP_W-1:0]       sample0;
    logic [SAMP_W-1:0]       sample1;
    logic [SAMP_W-1:0]       sample2;
    logic [SAMP_W-1:0]       sample3;
    logic signed [WGT_W-1:0] weight;
    logic                    last_tap;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel0;
    logic [PIX_W-1:0] pixel1;
    logic [PIX_W-1:0] pixel2;
    logic [PIX_W-1:0] pixel3;
  } out_t;

  // Per-lane controls driven by the top level pipeline
  typedef struct packed {
    logic load;  // tap transfer into the product stage
    logic adv;   // product stage moves into the accumulator
    logic last;  // product stage holds the final tap of a pixel
  } lane_ctl_t;

  // Rounding offset 2^(precision-1), zero for precision zero
  function automatic logic [ACC_W-1:0] round_offset(input logic [PREC_W-1:0] prec);
    logic [ACC_W-1:0] r;
    r = '0;
    if (prec != '0) begin
      r = ACC_W'(1) << (prec - PREC_W'(1));
    end
    return r;
  endfunction

  localparam logic [ACC_W-1:0] ROUND_RESET = round_offset(PRECISION_RESET);

endpackage

// File: hdl/ptmr_lane.sv
// ----------------------------------------------------------------------------
// ptmr_lane
// One channel lane: registered sample-by-weight product, then a 32-bit
// wrapping accumulator that hands its sum on at the last tap and reloads.
// ----------------------------------------------------------------------------
module ptmr_lane
  import ptmr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  lane_ctl_t               ctl,
  input  logic [SAMP_W-1:0]       sample,
  input  logic signed [WGT_W-1:0] weight,
  input  logic [ACC_W-1:0]        offset,
  output logic [ACC_W-1:0]        sum
);

  logic signed [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]         acc_r;
  logic [ACC_W-1:0]         sum_r;
  logic [ACC_W-1:0]         acc_add;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod_r <= weight * $signed({1'b0, sample});
    end
  end

  assign acc_add = acc_r + ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= ROUND_RESET;
    end else if (ctl.adv) begin
      acc_r <= ctl.last ? offset : acc_add;
    end
  end

  // hold the finished sum for the output stage
  always_ff @(posedge clk) begin
    if (ctl.adv && ctl.last) begin
      sum_r <= acc_add;
    end
  end

  assign sum = sum_r;

endmodule

// File: hdl/ptmr_merge.sv
// ----------------------------------------------------------------------------
// ptmr_merge
// Merge stage: shift and clamp each lane sum, blank unused lanes and
// register the pixel for the output transfer.
// ----------------------------------------------------------------------------
module ptmr_merge
  import ptmr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              out_ready,
  input  logic [PREC_W-1:0] precision,
  input  logic [CHAN_W-1:0] channel_count,
  input  logic [ACC_W-1:0]  sums [LANES],
  output logic              out_valid,
  output out_t              out_data
);

  logic             out_valid_r;
  logic             out_valid_nxt;
  out_t             out_data_r;
  logic [PIX_W-1:0] pix [OUT_FIELDS];

  for (genvar i = 0; i < OUT_FIELDS; i++) begin : g_pix
    if (i < LANES) begin : g_used
      logic [ACC_W-1:0] shifted;
      assign shifted = sums[i] >> precision;
      always_comb begin
        pix[i] = '0;
        if (CHAN_W'(i) < channel_count && !sums[i][ACC_W-1]) begin
          pix[i] = (|shifted[ACC_W-1:PIX_W]) ? PIX_MAX : shifted[PIX_W-1:0];
        end
      end
    end else begin : g_none
      assign pix[i] = '0;
    end
  end

  assign out_valid_nxt = load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= '{pixel0: pix[0], pixel1: pix[1], pixel2: pix[2], pixel3: pix[3]};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/pixel_tap_mac_resampler_core.sv
// A last tap's pixel passes the product, sum and output registers in turn before it shows on out_data.
// Throughput: one tap per cycle; each lane has one multiplier and one 32-bit adder.
// A held output stalls input only when a last tap waits behind a full sum stage.
// Reset (rst_n, synchronous, active low): precision 12, channel count 3,
// accumulators at 2048, pipeline and output empty.
// ----------------------------------------------------------------------------
// pixel_tap_mac_resampler_core
// Resampling tap accumulator: LANES parallel multiply-accumulate lanes
// followed by a merge stage that shifts, clamps and emits one pixel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pixel_tap_mac_resampler_core
  import ptmr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // tap input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  // pixel output
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [PREC_W-1:0] precision_r;
  logic [CHAN_W-1:0] channel_count_r;

  // Pipeline control: S1 product stage, S2 holds a finished sum
  logic s1_valid_r, s1_valid_nxt;
  logic s1_last_r;
  logic s2_valid_r, s2_valid_nxt;
  logic in_xfer;
  logic s1_move;
  logic s2_ready;
  logic s3_ready;
  logic s2_load;
  logic s3_load;

  logic [ACC_W-1:0]  offset;
  logic [ACC_W-1:0]  sums    [LANES];
  logic [SAMP_W-1:0] samples [OUT_FIELDS];
  lane_ctl_t         lane_ctl;

  // Register writes are always taken; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      precision_r     <= PRECISION_RESET;
      channel_count_r <= CHANNELS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PRECISION: precision_r     <= cfg_data[PREC_W-1:0];
        REG_CHANNELS:  channel_count_r <= cfg_data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Ready chain: a non-last tap always drains into the accumulators;
  // a last tap needs the sum stage, which needs the output register.
  assign s3_ready = !out_valid || out_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_move  = !s1_last_r || s2_ready;
  assign in_ready = !s1_valid_r || s1_move;
  assign in_xfer  = in_valid && in_ready;
  assign s2_load  = s1_valid_r && s1_last_r && s2_ready;
  assign s3_load  = s2_valid_r && s3_ready;

  assign s1_valid_nxt = in_xfer || (s1_valid_r && !s1_move);
  assign s2_valid_nxt = s2_load || (s2_valid_r && !s3_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_last_r <= in_data.last_tap;
    end
  end

  // Reload value follows the current precision
  assign offset = round_offset(precision_r);

  assign lane_ctl = '{load: in_xfer, adv: s1_valid_r && s1_move, last: s1_last_r};

  assign samples[0] = in_data.sample0;
  assign samples[1] = in_data.sample1;
  assign samples[2] = in_data.sample2;
  assign samples[3] = in_data.sample3;

  // One multiply-accumulate lane per channel
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    ptmr_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (lane_ctl),
      .sample (samples[i]),
      .weight (in_data.weight),
      .offset (offset),
      .sum    (sums[i])
    );
  end

  // Shift, clamp and register the pixel
  ptmr_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (s3_load),
    .out_ready     (out_ready),
    .precision     (precision_r),
    .channel_count (channel_count_r),
    .sums          (sums),
    .out_valid     (out_valid),
    .out_data      (out_data)
  );

  // Input stalls only behind a last tap that cannot move on
  `ASSERT_IMPLY(a_stall_cause, clk, rst_n, !in_ready, s1_valid_r && s1_last_r && !s2_ready, "input stalled without a blocked last tap")
  // A last tap leaving the product stage leaves a sum pending
  `ASSERT_NEXT(a_sum_pending, clk, rst_n, s2_load, s2_valid_r, "finished sum lost")
  // A pending sum taken by the merge stage becomes an output transfer
  `ASSERT_NEXT(a_out_load, clk, rst_n, s3_load, out_valid, "pixel not presented")
  // The sum stage waits only while the output holds a pixel that is not taken
  `ASSERT_IMPLY(a_no_overrun, clk, rst_n, s2_valid_r && !s3_ready, out_valid && !out_ready, "sum stage blocked without output stall")

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// Resampling tap accumulator testbench
// Streams directed and random taps through pixel_tap_mac_resampler_core under
// several precision and channel settings. A local fixed-point model predicts
// every pixel, and the monitor checks each pixel transfer field by field.
// ----------------------------------------------------------------------------
module testbench
  import ptmr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Indexes past the last register; writes to them must have no effect
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 90;
  localparam int DRAIN_CYCLES = 6;      // margin over the product, sum and output registers
  localparam int STALL_CYCLES = 300;    // long receiver hold-off
  localparam int WRAP_TAPS    = 260;    // enough max-weight taps to set the sign bit
  localparam int CYCLE_LIMIT  = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shared between the sequence, the driver and the monitor
  in_t  pending_taps [$];
  out_t expected_pixels [$];
  int   src_idle_pct = 0;
  int   sink_idle_pct = 0;
  bit   sink_stall_req = 1'b0;
  bit   sink_stall_ack = 1'b0;
  int   stall_left = 0;
  int   fail_count = 0;
  int   cycle_count = 0;

  // Model state: accumulators and the two registers
  logic [ACC_W-1:0]  lane_sums [LANES];
  logic [PREC_W-1:0] prec_cfg;
  logic [CHAN_W-1:0] chan_cfg;

  // Monitor scratch
  out_t             want;
  logic [PIX_W-1:0] want_f;
  logic [PIX_W-1:0] got_f;
  string            pixel_names [OUT_FIELDS] = '{"pixel0", "pixel1", "pixel2", "pixel3"};

  pixel_tap_mac_resampler_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Rounding offset 2^(p-1); zero precision means no offset at all
  function automatic logic [ACC_W-1:0] lane_offset(input logic [PREC_W-1:0] p);
    return (p == '0) ? '0 : (ACC_W'(1) << (p - PREC_W'(1)));
  endfunction

  // Accumulate one tap into every lane; on a last tap, queue the pixel it closes
  function automatic void predict_tap(input in_t t);
    logic [SAMP_W-1:0] smp [LANES];
    logic [ACC_W-1:0]  wext;
    logic [ACC_W-1:0]  shifted;
    logic [PIX_W-1:0]  px [OUT_FIELDS];
    int                used;
    smp[0] = t.sample0;
    smp[1] = t.sample1;
    smp[2] = t.sample2;
    smp[3] = t.sample3;
    wext = {{(ACC_W-WGT_W){t.weight[WGT_W-1]}}, t.weight};
    // Unused lanes keep accumulating; only their outputs are masked
    for (int i = 0; i < LANES; i++) begin
      lane_sums[i] = lane_sums[i] + wext * ACC_W'(smp[i]);
    end
    if (!t.last_tap) begin
      return;
    end
    used = (chan_cfg > LANES) ? LANES : int'(chan_cfg);
    for (int i = 0; i < OUT_FIELDS; i++) begin
      px[i] = '0;
      // A set sign bit marks a negative sum, which clamps to zero
      if (i < used && !lane_sums[i][ACC_W-1]) begin
        shifted = lane_sums[i] >> prec_cfg;
        px[i] = (shifted > PIX_MAX) ? PIX_MAX : shifted[PIX_W-1:0];
      end
    end
    expected_pixels.push_back(out_t'{pixel0: px[0], pixel1: px[1], pixel2: px[2],
                                     pixel3: px[3]});
    for (int i = 0; i < LANES; i++) begin
      lane_sums[i] = lane_offset(prec_cfg);
    end
  endfunction

  task automatic push_tap(input logic [7:0] s0, input logic [7:0] s1, input logic [7:0] s2,
                          input logic [7:0] s3, input logic [15:0] w, input logic is_last);
    in_t t;
    t.sample0  = s0;
    t.sample1  = s1;
    t.sample2  = s2;
    t.sample3  = s3;
    t.weight   = w;
    t.last_tap = is_last;
    pending_taps.push_back(t);
  endtask

  // Queue pixels with random content; most are well formed with weights that sum
  // near unity, some are broken runs with raw weights and random last flags
  task automatic fill_random(input int count, input logic [PREC_W-1:0] p);
    int  added;
    int  n;
    int  base;
    int  w;
    bit  broken;
    in_t t;
    added = 0;
    while (added < count) begin
      broken = ($urandom_range(99) < 15);
      n = broken ? $urandom_range(1, 12) : $urandom_range(1, 6);
      base = (p == '0) ? 1 : (1 << p) / n;
      for (int k = 0; k < n; k++) begin
        t.sample0 = 8'($urandom);
        t.sample1 = 8'($urandom);
        t.sample2 = 8'($urandom);
        t.sample3 = 8'($urandom);
        if (!broken && $urandom_range(99) < 80) begin
          w = base - base / 4 + int'($urandom_range(0, base / 2 + 1));
        end else begin
          w = int'($urandom_range(0, 65535)) - 32768;
        end
        if (w > 32767) begin
          w = 32767;
        end
        t.weight   = 16'(w);
        t.last_tap = broken ? ($urandom_range(1) == 1) : (k == n - 1);
        pending_taps.push_back(t);
      end
      added += n;
    end
  endtask

  // Wait for the input queue and every expected pixel to drain, then let the
  // pipeline settle in case a non-last tap is still in flight
  task automatic wait_idle();
    while (pending_taps.size() != 0 || in_valid || expected_pixels.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register transfer; update the model once the handshake completes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_PRECISION) begin
      prec_cfg = val[PREC_W-1:0];
    end else if (idx == REG_CHANNELS) begin
      chan_cfg = val[CHAN_W-1:0];
    end
  endtask

  // Driver: hold the payload until it transfers, then offer the next tap or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_tap(in_data);
      end
      if (!in_valid || in_ready) begin
        if (pending_taps.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_data  <= pending_taps.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each pixel transfer against the oldest expectation and
  // drive out_ready, including the long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel transfer with nothing expected: %h", out_data);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          for (int i = 0; i < OUT_FIELDS; i++) begin
            want_f = PIX_W'(want >> (PIX_W * (OUT_FIELDS - 1 - i)));
            got_f  = PIX_W'(out_data >> (PIX_W * (OUT_FIELDS - 1 - i)));
            if (want_f !== got_f) begin
              $error("%s: expected %0d, got %0d", pixel_names[i], want_f, got_f);
              fail_count++;
            end
          end
        end
      end
      if (sink_stall_req != sink_stall_ack) begin
        sink_stall_ack <= sink_stall_req;
        stall_left     <= STALL_CYCLES;
        out_ready      <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // End the run if it hangs
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("pixel_tap_mac_resampler_core verification failed");
    $finish;
  end

  initial begin : sequencer
    logic [PREC_W-1:0] prec_plan [PHASES];
    logic [CHAN_W-1:0] chan_plan [PHASES];
    int                src_plan  [PHASES];
    int                sink_plan [PHASES];
    // Extremes first: max lanes, min precision, no lanes, zero precision,
    // lane count above the lane total
    prec_plan = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd14, 4'd12, 4'd10, 4'd15};
    chan_plan = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd5, 3'd2, 3'd3, 3'd4};
    src_plan  = '{13, 13, 13, 83, 83, 83, 0, 0};
    sink_plan = '{83, 83, 83, 13, 13, 13, 0, 0};

    prec_cfg = PRECISION_RESET;
    chan_cfg = CHANNELS_RESET;
    for (int i = 0; i < LANES; i++) begin
      lane_sums[i] = lane_offset(PRECISION_RESET);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed taps at the reset settings
    @(negedge clk);
    push_tap(8'd255, 8'd255, 8'd255, 8'd255, 16'd4096, 1'b1);  // unity weight, full scale
    push_tap(8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 1'b1);             // offset only
    push_tap(8'd255, 8'd255, 8'd255, 8'd255, 16'h8000, 1'b1);  // most negative weight
    push_tap(8'd255, 8'd255, 8'd255, 8'd255, 16'h7fff, 1'b1);  // clamp high
    push_tap(8'd128, 8'd64, 8'd32, 8'd16, 16'd2048, 1'b0);
    push_tap(8'd128, 8'd64, 8'd32, 8'd16, 16'd2048, 1'b1);
    push_tap(8'd1, 8'd2, 8'd3, 8'd4, 16'd1, 1'b1);
    push_tap(8'haa, 8'h55, 8'hf0, 8'h0f, 16'h5555, 1'b1);
    push_tap(8'h55, 8'haa, 8'h0f, 8'hf0, 16'haaaa, 1'b0);
    push_tap(8'hff, 8'h80, 8'h01, 8'h7f, 16'h7fff, 1'b1);
    push_tap(8'd200, 8'd100, 8'd50, 8'd250, 16'd1024, 1'b0);
    push_tap(8'd10, 8'd20, 8'd30, 8'd40, 16'd1024, 1'b0);
    push_tap(8'd90, 8'd180, 8'd250, 8'd5, 16'd1024, 1'b0);
    push_tap(8'd60, 8'd70, 8'd80, 8'd90, 16'd1024, 1'b1);
    push_tap(8'd255, 8'd255, 8'd0, 8'd255, -16'sd1000, 1'b0);  // dip below zero, recover
    push_tap(8'd255, 8'd255, 8'd0, 8'd255, 16'd5096, 1'b1);
    push_tap(8'd255, 8'd0, 8'd255, 8'd0, 16'hffff, 1'b1);      // minus one
    // Leave a pixel open so the next precision write lands mid-pixel
    push_tap(8'd77, 8'd150, 8'd33, 8'd201, 16'd700, 1'b0);
    push_tap(8'd12, 8'd240, 8'd99, 8'd3, 16'd900, 1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      // Random upper bits: only the low field bits of each register count
      write_reg(REG_PRECISION, (CFG_DATA_W'($urandom) & 8'hf0) | CFG_DATA_W'(prec_plan[ph]));
      write_reg(REG_CHANNELS, (CFG_DATA_W'($urandom) & 8'hf8) | CFG_DATA_W'(chan_plan[ph]));
      if (ph == 0) begin
        write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
      end else if (ph == 3) begin
        write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
      end
      @(negedge clk);
      src_idle_pct  <= src_plan[ph];
      sink_idle_pct <= sink_plan[ph];
      if (ph == 1) begin
        // Pause the sender until every queued pixel has come out
        fill_random(PHASE_ITEMS / 2, prec_plan[ph]);
        wait_idle();
        @(negedge clk);
        fill_random(PHASE_ITEMS - PHASE_ITEMS / 2, prec_plan[ph]);
      end else if (ph == 6) begin
        // Hold off the receiver while taps keep coming, so the core backs up
        sink_stall_req <= ~sink_stall_req;
        fill_random(PHASE_ITEMS, prec_plan[ph]);
      end else if (ph == 7) begin
        // Push one pixel's sums past the sign bit
        for (int k = 0; k < WRAP_TAPS; k++) begin
          push_tap(8'd255, 8'd255, 8'd255, 8'd255, 16'h7fff, k == WRAP_TAPS - 1);
        end
        fill_random(PHASE_ITEMS, prec_plan[ph]);
      end else begin
        fill_random(PHASE_ITEMS, prec_plan[ph]);
      end
    end

    wait_idle();
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_pixels.size() == 0) begin
      $display("pixel_tap_mac_resampler_core verification clean");
    end else begin
      $display("pixel_tap_mac_resampler_core verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/ptmr_pkg.sv
hdl/ptmr_lane.sv
hdl/ptmr_merge.sv
hdl/pixel_tap_mac_resampler_core.sv
sim/testbench.sv
